### hdl/cpu_effective_address_unit_macros.svh
// Assertion macros used by the effective-address unit top level.
`ifndef CPU_EFFECTIVE_ADDRESS_UNIT_MACROS_SVH
`define CPU_EFFECTIVE_ADDRESS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define CEAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ceau check failed");

// Next-cycle implication, checked outside reset
`define CEAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ceau check failed");

`else

`define CEAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CEAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/ceau_pkg.sv
// Types, codes and helper functions of the effective-address unit.
package ceau_pkg;

    // Register file geometry: D0-D7 at 0-7, A0-A7 at 8-15
    localparam int unsigned RF_DEPTH = 16;
    localparam int unsigned RF_WIDTH = 32;
    localparam int unsigned RF_AW    = 4;

    // Addressing modes
    localparam logic [2:0] MODE_DREG   = 3'd0;
    localparam logic [2:0] MODE_AREG   = 3'd1;
    localparam logic [2:0] MODE_IND    = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC = 3'd4;
    localparam logic [2:0] MODE_DISP   = 3'd5;
    localparam logic [2:0] MODE_INDEX  = 3'd6;
    localparam logic [2:0] MODE_EXT    = 3'd7;

    // Mode 7 submodes
    localparam logic [2:0] SUB_ABS_W   = 3'd0;
    localparam logic [2:0] SUB_ABS_L   = 3'd1;
    localparam logic [2:0] SUB_PC_DISP = 3'd2;
    localparam logic [2:0] SUB_PC_IDX  = 3'd3;
    localparam logic [2:0] SUB_IMM     = 3'd4;

    // Operand sizes
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;

    // Request types
    localparam logic REQ_DECODE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    // Stack pointer register number
    localparam logic [2:0] SP_REG = 3'd7;

    // Operand kinds
    typedef enum logic [1:0] {
        KIND_DREG = 2'd0,
        KIND_AREG = 2'd1,
        KIND_MEM  = 2'd2,
        KIND_IMM  = 2'd3
    } t_kind;

    // One request item
    typedef struct packed {
        logic        req_type;
        logic [2:0]  ea_mode;
        logic [2:0]  ea_reg;
        logic [1:0]  op_size;
        logic [15:0] ext_word;
        logic [31:0] ext_long;
        logic [31:0] pc_value;
        logic [3:0]  write_reg;
        logic [31:0] write_value;
    } t_req;

    // One result item
    typedef struct packed {
        t_kind       ea_kind;
        logic [31:0] ea_address;
        logic [31:0] operand_value;
        logic [1:0]  ext_words_used;
    } t_res;

    // Register write-back
    typedef struct packed {
        logic               en;
        logic [RF_AW-1:0]   addr;
        logic [RF_WIDTH-1:0] data;
    } t_wb;

    function automatic logic [31:0] size_mask(input logic [1:0] sz);
        logic [31:0] m;
        case (sz)
            SIZE_BYTE: m = 32'h0000_00FF;
            SIZE_WORD: m = 32'h0000_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    // Register that the primary operand port reads for a request
    function automatic logic [RF_AW-1:0] port_a_addr(input t_req r);
        logic [RF_AW-1:0] a;
        if (r.req_type == REQ_WRITE) begin
            a = r.write_reg;
        end else if (r.ea_mode == MODE_DREG) begin
            a = {1'b0, r.ea_reg};
        end else if (r.ea_mode == MODE_EXT) begin
            // only the unassigned submodes read a register (D0)
            a = '0;
        end else begin
            a = {1'b1, r.ea_reg};
        end
        return a;
    endfunction

    // Index register named by a brief extension word
    function automatic logic [RF_AW-1:0] port_b_addr(input t_req r);
        return {r.ext_word[15], r.ext_word[14:12]};
    endfunction

endpackage

### hdl/ceau_ram.sv
// Generic RAM: one write port, two registered read ports.
module ceau_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### hdl/ceau_regfile.sv
// D0-D7/A0-A7 register file: RAM, per-entry valid bits and write bypass.
module ceau_regfile (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_rd_en,
    input  logic [ceau_pkg::RF_AW-1:0]        i_rd_addr_a,
    input  logic [ceau_pkg::RF_AW-1:0]        i_rd_addr_b,
    input  ceau_pkg::t_wb                     i_wb,
    output logic [ceau_pkg::RF_WIDTH-1:0]     o_rd_data_a,
    output logic [ceau_pkg::RF_WIDTH-1:0]     o_rd_data_b
);

    logic [ceau_pkg::RF_DEPTH-1:0] r_valid;
    logic                          r_ok_a;
    logic                          r_ok_b;
    logic                          r_fwd_a;
    logic                          r_fwd_b;
    logic [ceau_pkg::RF_WIDTH-1:0] r_fwd_data;
    logic [ceau_pkg::RF_WIDTH-1:0] ram_a;
    logic [ceau_pkg::RF_WIDTH-1:0] ram_b;
    logic                          hit_a;
    logic                          hit_b;

    ceau_ram #(
        .WIDTH (ceau_pkg::RF_WIDTH),
        .DEPTH (ceau_pkg::RF_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_wb.en),
        .i_waddr   (i_wb.addr),
        .i_wdata   (i_wb.data),
        .i_re      (i_rd_en),
        .i_raddr_a (i_rd_addr_a),
        .i_raddr_b (i_rd_addr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // a write in the read cycle wins over the RAM's old data
    assign hit_a = i_wb.en && (i_wb.addr == i_rd_addr_a);
    assign hit_b = i_wb.en && (i_wb.addr == i_rd_addr_b);

    // valid bits: entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wb.en) begin
            r_valid[i_wb.addr] <= 1'b1;
        end
    end

    // read-side select flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok_a  <= 1'b0;
            r_ok_b  <= 1'b0;
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
        end else if (i_rd_en) begin
            r_ok_a  <= r_valid[i_rd_addr_a];
            r_ok_b  <= r_valid[i_rd_addr_b];
            r_fwd_a <= hit_a;
            r_fwd_b <= hit_b;
        end
    end

    // bypassed write data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wb.data;
        end
    end

    assign o_rd_data_a = r_fwd_a ? r_fwd_data : (r_ok_a ? ram_a : '0);
    assign o_rd_data_b = r_fwd_b ? r_fwd_data : (r_ok_b ? ram_b : '0);

endmodule

### hdl/ceau_calc.sv
// Address arithmetic, operand selection and register write-back for one item.
module ceau_calc (
    input  ceau_pkg::t_req  i_req,
    input  logic [31:0]     i_opa,
    input  logic [31:0]     i_idx,
    output ceau_pkg::t_res  o_res,
    output ceau_pkg::t_wb   o_wb
);

    logic [31:0] mask;
    logic [2:0]  step;
    logic [31:0] step32;
    logic [31:0] idx_val;
    logic [31:0] ioff;
    logic [31:0] dmerge;
    logic [31:0] awrite;
    logic [31:0] a_dec;

    // shared terms
    always_comb begin
        mask = ceau_pkg::size_mask(i_req.op_size);
        case (i_req.op_size)
            ceau_pkg::SIZE_BYTE: step = (i_req.ea_reg == ceau_pkg::SP_REG) ? 3'd2 : 3'd1;
            ceau_pkg::SIZE_WORD: step = 3'd2;
            default:             step = 3'd4;
        endcase
        step32  = {29'd0, step};
        idx_val = i_req.ext_word[11] ? i_idx : ceau_pkg::sext16(i_idx[15:0]);
        ioff    = ceau_pkg::sext8(i_req.ext_word[7:0]) + idx_val;
        dmerge  = (i_opa & ~mask) | (i_req.write_value & mask);
        awrite  = (i_req.op_size == ceau_pkg::SIZE_WORD)
                ? ceau_pkg::sext16(i_req.write_value[15:0]) : i_req.write_value;
        a_dec   = i_opa - step32;
    end

    // result and write-back
    always_comb begin
        o_res.ea_kind        = ceau_pkg::KIND_MEM;
        o_res.ea_address     = '0;
        o_res.operand_value  = '0;
        o_res.ext_words_used = 2'd0;
        o_wb.en              = 1'b0;
        o_wb.addr            = {1'b1, i_req.ea_reg};
        o_wb.data            = i_opa + step32;

        if (i_req.req_type == ceau_pkg::REQ_WRITE) begin
            o_wb.en          = 1'b1;
            o_wb.addr        = i_req.write_reg;
            o_res.ea_address = {29'd0, i_req.write_reg[2:0]};
            if (!i_req.write_reg[3]) begin
                o_wb.data           = dmerge;
                o_res.ea_kind       = ceau_pkg::KIND_DREG;
                o_res.operand_value = dmerge & mask;
            end else begin
                o_wb.data           = awrite;
                o_res.ea_kind       = ceau_pkg::KIND_AREG;
                o_res.operand_value = awrite & mask;
            end
        end else begin
            unique case (i_req.ea_mode)
                ceau_pkg::MODE_DREG: begin
                    o_res.ea_kind       = ceau_pkg::KIND_DREG;
                    o_res.ea_address    = {29'd0, i_req.ea_reg};
                    o_res.operand_value = i_opa & mask;
                end
                ceau_pkg::MODE_AREG: begin
                    o_res.ea_kind       = ceau_pkg::KIND_AREG;
                    o_res.ea_address    = {29'd0, i_req.ea_reg};
                    o_res.operand_value = i_opa & mask;
                end
                ceau_pkg::MODE_IND: begin
                    o_res.ea_address = i_opa;
                end
                ceau_pkg::MODE_POSTINC: begin
                    o_res.ea_address = i_opa;
                    o_wb.en          = 1'b1;
                end
                ceau_pkg::MODE_PREDEC: begin
                    o_res.ea_address = a_dec;
                    o_wb.en          = 1'b1;
                    o_wb.data        = a_dec;
                end
                ceau_pkg::MODE_DISP: begin
                    o_res.ea_address     = i_opa + ceau_pkg::sext16(i_req.ext_word);
                    o_res.ext_words_used = 2'd1;
                end
                ceau_pkg::MODE_INDEX: begin
                    o_res.ea_address     = i_opa + ioff;
                    o_res.ext_words_used = 2'd1;
                end
                ceau_pkg::MODE_EXT: begin
                    unique case (i_req.ea_reg)
                        ceau_pkg::SUB_ABS_W: begin
                            o_res.ea_address     = ceau_pkg::sext16(i_req.ext_word);
                            o_res.ext_words_used = 2'd1;
                        end
                        ceau_pkg::SUB_ABS_L: begin
                            o_res.ea_address     = i_req.ext_long;
                            o_res.ext_words_used = 2'd2;
                        end
                        ceau_pkg::SUB_PC_DISP: begin
                            o_res.ea_address     = i_req.pc_value
                                                 + ceau_pkg::sext16(i_req.ext_word);
                            o_res.ext_words_used = 2'd1;
                        end
                        ceau_pkg::SUB_PC_IDX: begin
                            o_res.ea_address     = i_req.pc_value + ioff;
                            o_res.ext_words_used = 2'd1;
                        end
                        ceau_pkg::SUB_IMM: begin
                            o_res.ea_kind = ceau_pkg::KIND_IMM;
                            if (i_req.op_size[1]) begin
                                o_res.operand_value  = i_req.ext_long;
                                o_res.ext_words_used = 2'd2;
                            end else begin
                                o_res.operand_value  = {16'd0, i_req.ext_word} & mask;
                                o_res.ext_words_used = 2'd1;
                            end
                        end
                        default: begin
                            // unassigned submodes answer as D0
                            o_res.ea_kind       = ceau_pkg::KIND_DREG;
                            o_res.operand_value = i_opa & mask;
                        end
                    endcase
                end
                default: begin
                    o_res.ea_kind = ceau_pkg::KIND_MEM;
                end
            endcase
        end
    end

endmodule

### hdl/cpu_effective_address_unit.sv
// Top level of the effective-address unit: input stage, register file, result register.
//
//  Channel  Direction  Signals                       Payload
//  s_axis   in         tvalid tready tdata tuser     request item (tuser: req_type)
//  m_axis   out        tvalid tready tdata tuser     result item (tuser: ea_kind)
//
// One item per cycle while i_m_axis_tready is high; o_m_axis_tvalid marks a loaded result:
// the register file read is registered at accept, then the address add and the register
// update happen as the result register loads. A write is bypassed to the next item's read.
// Reset is synchronous, active low; unwritten registers read as zero via per-entry valid bits.
// o_s_axis_tready drops only while both stages are full and i_m_axis_tready is low.
`include "cpu_effective_address_unit_macros.svh"

module cpu_effective_address_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [2:0] ea_mode, [5:3] ea_reg, [7:6] op_size, [23:8] ext_word,
    // [55:24] ext_long, [87:56] pc_value, [91:88] write_reg,
    // [123:92] write_value, [127:124] zero
    input  logic [127:0] i_s_axis_tdata,
    // [0] req_type
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] ea_address, [63:32] operand_value, [65:64] ext_words_used,
    // [71:66] zero
    output logic [71:0]  o_m_axis_tdata,
    // [1:0] ea_kind
    output logic [1:0]   o_m_axis_tuser
);

    ceau_pkg::t_req r_in;
    logic           r_in_valid;
    ceau_pkg::t_res r_out;
    logic           r_out_valid;

    ceau_pkg::t_req in_req;
    ceau_pkg::t_res calc_res;
    ceau_pkg::t_wb  calc_wb;
    ceau_pkg::t_wb  wb;
    logic           in_acc;
    logic           adv;
    logic           fire;
    logic [31:0]    opa;
    logic [31:0]    idx;

    // unpack the incoming item
    always_comb begin
        in_req.req_type    = i_s_axis_tuser;
        in_req.ea_mode     = i_s_axis_tdata[2:0];
        in_req.ea_reg      = i_s_axis_tdata[5:3];
        in_req.op_size     = i_s_axis_tdata[7:6];
        in_req.ext_word    = i_s_axis_tdata[23:8];
        in_req.ext_long    = i_s_axis_tdata[55:24];
        in_req.pc_value    = i_s_axis_tdata[87:56];
        in_req.write_reg   = i_s_axis_tdata[91:88];
        in_req.write_value = i_s_axis_tdata[123:92];
    end

    // handshake: the stage moves when the result register is free or drains
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && adv;
    assign o_s_axis_tready = !r_in_valid || adv;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // register updates only when the item leaves the stage
    always_comb begin
        wb    = calc_wb;
        wb.en = calc_wb.en && fire;
    end

    ceau_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (ceau_pkg::port_a_addr(in_req)),
        .i_rd_addr_b (ceau_pkg::port_b_addr(in_req)),
        .i_wb        (wb),
        .o_rd_data_a (opa),
        .o_rd_data_b (idx)
    );

    ceau_calc u_calc (
        .i_req (r_in),
        .i_opa (opa),
        .i_idx (idx),
        .o_res (calc_res),
        .o_wb  (calc_wb)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= in_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= calc_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.ea_kind;
    assign o_m_axis_tdata  = {6'd0, r_out.ext_words_used, r_out.operand_value,
                              r_out.ea_address};

    // checks
    `CEAU_ASSERT_IMP(a_stall_only_full, i_clk, i_rst_n, !o_s_axis_tready,
        r_in_valid && r_out_valid && !i_m_axis_tready)
    `CEAU_ASSERT_NXT(a_accept_fills, i_clk, i_rst_n, in_acc, r_in_valid)
    `CEAU_ASSERT_NXT(a_fire_gives_result, i_clk, i_rst_n, fire, o_m_axis_tvalid)
    `CEAU_ASSERT_IMP(a_no_write_on_stall, i_clk, i_rst_n, wb.en, fire)
    `CEAU_ASSERT_IMP(a_ext_count, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata[65:64] != 2'd3)

endmodule

### dv/cpu_effective_address_unit_tb.sv
// Self-checking testbench for the effective-address unit: driver, predictor, checker.
`timescale 1ns / 100ps

module cpu_effective_address_unit_tb;

    // Size codes not named in the package; the out-of-range code behaves as long
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_ODD  = 2'd3;

    // Mode 7 submodes with no addressing mode behind them
    localparam logic [2:0] SUB_SPARE_LO = 3'd5;
    localparam logic [2:0] SUB_SPARE_HI = 3'd7;

    localparam int          RANDOM_ITEMS = 625;
    localparam int          TAIL_ITEMS   = 100;  // no idling once this few remain
    localparam int unsigned HOLD_AT      = 150;  // items accepted before the long stall
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int          PAUSE_AT     = 300;  // random item that waits for an empty pipe
    localparam int          MAX_PRINTS   = 40;

    typedef struct {
        ceau_pkg::t_req req;
        bit             wait_idle;  // hold this item until every result is back
    } t_req_slot;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_ready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [71:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    ceau_pkg::t_req s_item = '0;
    t_req_slot      request_fifo [$];
    ceau_pkg::t_res expected_ops [$];
    logic [31:0]    dreg_model [8] = '{default: '0};
    logic [31:0]    areg_model [8] = '{default: '0};
    int unsigned    items_accepted = 0;
    int unsigned    results_seen = 0;
    int unsigned    mismatches = 0;
    int unsigned    send_gap = 0;
    int unsigned    recv_gap = 0;
    int unsigned    hold_left = 0;
    bit             hold_done = 1'b0;

    cpu_effective_address_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock and reset
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("FAIL cpu_effective_address_unit");
        $finish;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] sx16(input logic [15:0] v);
        logic signed [31:0] w;
        w = $signed(v);
        return w;
    endfunction

    function automatic logic [31:0] sx8(input logic [7:0] v);
        logic signed [31:0] w;
        w = $signed(v);
        return w;
    endfunction

    function automatic logic [31:0] width_mask(input logic [1:0] sz);
        if (sz == ceau_pkg::SIZE_BYTE) return 32'h0000_00FF;
        if (sz == ceau_pkg::SIZE_WORD) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    // Displacement plus scaled-free index from a brief extension word
    function automatic logic [31:0] brief_index(input logic [15:0] ew);
        logic [31:0] xv;
        xv = ew[15] ? areg_model[ew[14:12]] : dreg_model[ew[14:12]];
        if (!ew[11]) xv = sx16(xv[15:0]);
        return sx8(ew[7:0]) + xv;
    endfunction

    // Operand descriptor for one request; updates the register copies
    function automatic ceau_pkg::t_res model_operand(input ceau_pkg::t_req r);
        ceau_pkg::t_res o;
        logic [31:0]    m;
        logic [31:0]    step;
        logic [2:0]     n;
        o.ea_kind        = ceau_pkg::KIND_MEM;
        o.ea_address     = '0;
        o.operand_value  = '0;
        o.ext_words_used = '0;
        m = width_mask(r.op_size);
        if (r.req_type == ceau_pkg::REQ_WRITE) begin
            n = r.write_reg[2:0];
            if (!r.write_reg[3]) begin
                // data register: merge sized low part
                dreg_model[n]   = (dreg_model[n] & ~m) | (r.write_value & m);
                o.ea_kind       = ceau_pkg::KIND_DREG;
                o.operand_value = dreg_model[n] & m;
            end else begin
                // address register: word writes sign-extend
                areg_model[n]   = (r.op_size == ceau_pkg::SIZE_WORD)
                                ? sx16(r.write_value[15:0]) : r.write_value;
                o.ea_kind       = ceau_pkg::KIND_AREG;
                o.operand_value = areg_model[n] & m;
            end
            o.ea_address = {29'd0, n};
        end else begin
            n = r.ea_reg;
            if (r.op_size == ceau_pkg::SIZE_BYTE) step = (n == ceau_pkg::SP_REG) ? 32'd2 : 32'd1;
            else if (r.op_size == ceau_pkg::SIZE_WORD) step = 32'd2;
            else step = 32'd4;
            case (r.ea_mode)
                ceau_pkg::MODE_DREG: begin
                    o.ea_kind       = ceau_pkg::KIND_DREG;
                    o.ea_address    = {29'd0, n};
                    o.operand_value = dreg_model[n] & m;
                end
                ceau_pkg::MODE_AREG: begin
                    o.ea_kind       = ceau_pkg::KIND_AREG;
                    o.ea_address    = {29'd0, n};
                    o.operand_value = areg_model[n] & m;
                end
                ceau_pkg::MODE_IND: o.ea_address = areg_model[n];
                ceau_pkg::MODE_POSTINC: begin
                    o.ea_address  = areg_model[n];
                    areg_model[n] = areg_model[n] + step;
                end
                ceau_pkg::MODE_PREDEC: begin
                    areg_model[n] = areg_model[n] - step;
                    o.ea_address  = areg_model[n];
                end
                ceau_pkg::MODE_DISP: begin
                    o.ea_address     = areg_model[n] + sx16(r.ext_word);
                    o.ext_words_used = 2'd1;
                end
                ceau_pkg::MODE_INDEX: begin
                    o.ea_address     = areg_model[n] + brief_index(r.ext_word);
                    o.ext_words_used = 2'd1;
                end
                default: begin
                    case (n)
                        ceau_pkg::SUB_ABS_W: begin
                            o.ea_address     = sx16(r.ext_word);
                            o.ext_words_used = 2'd1;
                        end
                        ceau_pkg::SUB_ABS_L: begin
                            o.ea_address     = r.ext_long;
                            o.ext_words_used = 2'd2;
                        end
                        ceau_pkg::SUB_PC_DISP: begin
                            o.ea_address     = r.pc_value + sx16(r.ext_word);
                            o.ext_words_used = 2'd1;
                        end
                        ceau_pkg::SUB_PC_IDX: begin
                            o.ea_address     = r.pc_value + brief_index(r.ext_word);
                            o.ext_words_used = 2'd1;
                        end
                        ceau_pkg::SUB_IMM: begin
                            o.ea_kind = ceau_pkg::KIND_IMM;
                            if (r.op_size[1]) begin
                                o.operand_value  = r.ext_long;
                                o.ext_words_used = 2'd2;
                            end else begin
                                o.operand_value  = {16'd0, r.ext_word} & m;
                                o.ext_words_used = 2'd1;
                            end
                        end
                        default: begin
                            // unassigned submode reads as D0
                            o.ea_kind       = ceau_pkg::KIND_DREG;
                            o.operand_value = dreg_model[0] & m;
                        end
                    endcase
                end
            endcase
        end
        return o;
    endfunction

    // ---------------------------------------------------------------
    // Mismatch reporting
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] result %0d: %s got %h expected %h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        t_req_slot slot;
        if (!i_rst_n) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            // item taken at this edge: predict its result
            if (s_valid && o_s_axis_tready) begin
                expected_ops.push_back(model_operand(s_item));
                items_accepted <= items_accepted + 1;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (request_fifo.size() == 0 ||
                             (request_fifo[0].wait_idle && expected_ops.size() != 0)) begin
                    s_valid <= 1'b0;
                end else if (request_fifo.size() > TAIL_ITEMS &&
                             $urandom_range(0, 5) == 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= $urandom_range(0, 2);
                end else begin
                    slot    = request_fifo.pop_front();
                    s_item  <= slot.req;
                    s_valid <= 1'b1;
                    s_tuser <= slot.req.req_type;
                    s_tdata <= {4'd0, slot.req.write_value, slot.req.write_reg,
                                slot.req.pc_value, slot.req.ext_long, slot.req.ext_word,
                                slot.req.op_size, slot.req.ea_reg, slot.req.ea_mode};
                end
            end
        end
    end

    // Long receiver stall once the run is under way
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        ceau_pkg::t_res want;
        if (!i_rst_n) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_ops.size() == 0) begin
                    report_mismatch("unexpected item, ea_address", o_m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_ops.pop_front();
                    if (o_m_axis_tuser !== want.ea_kind)
                        report_mismatch("ea_kind", {30'd0, o_m_axis_tuser},
                                        {30'd0, want.ea_kind});
                    if (o_m_axis_tdata[31:0] !== want.ea_address)
                        report_mismatch("ea_address", o_m_axis_tdata[31:0], want.ea_address);
                    if (o_m_axis_tdata[63:32] !== want.operand_value)
                        report_mismatch("operand_value", o_m_axis_tdata[63:32],
                                        want.operand_value);
                    if (o_m_axis_tdata[65:64] !== want.ext_words_used)
                        report_mismatch("ext_words_used", {30'd0, o_m_axis_tdata[65:64]},
                                        {30'd0, want.ext_words_used});
                end
                results_seen++;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                m_ready  <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else if (request_fifo.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                m_ready  <= 1'b0;
                recv_gap <= $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_req(input logic rt, input logic [2:0] md, input logic [2:0] rg,
                             input logic [1:0] sz, input logic [15:0] ew,
                             input logic [31:0] el, input logic [31:0] pc,
                             input logic [3:0] wr, input logic [31:0] wv);
        t_req_slot slot;
        slot.req = '{req_type: rt, ea_mode: md, ea_reg: rg, op_size: sz, ext_word: ew,
                     ext_long: el, pc_value: pc, write_reg: wr, write_value: wv};
        slot.wait_idle = 1'b0;
        request_fifo.push_back(slot);
    endtask

    // 32-bit value with a bias toward sign and wrap boundaries
    function automatic logic [31:0] pick_word32();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_8000 | ($urandom & 32'hFFFF_0000);
            3:       return 32'h0000_7FFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic ceau_pkg::t_req random_request();
        ceau_pkg::t_req r;
        r.req_type    = ($urandom_range(0, 99) < 30) ? ceau_pkg::REQ_WRITE
                                                     : ceau_pkg::REQ_DECODE;
        r.ea_mode     = 3'($urandom_range(0, 7));
        r.ea_reg      = ($urandom_range(0, 3) == 0) ? ceau_pkg::SP_REG
                                                    : 3'($urandom_range(0, 7));
        r.op_size     = ($urandom_range(0, 19) == 0) ? SZ_ODD : 2'($urandom_range(0, 2));
        r.ext_word    = 16'($urandom);
        r.ext_long    = pick_word32();
        r.pc_value    = pick_word32();
        r.write_reg   = 4'($urandom_range(0, 15));
        r.write_value = pick_word32();
        return r;
    endfunction

    initial begin : stimulus
        t_req_slot slot;
        // register writes: data merges, address sign extension, odd size
        queue_req(ceau_pkg::REQ_WRITE, ceau_pkg::MODE_DREG, 3'd0, SZ_LONG,
                  16'h0, 32'h0, 32'h0, 4'd3, 32'hFFFF_FFFF);
        queue_req(ceau_pkg::REQ_WRITE, ceau_pkg::MODE_DREG, 3'd0, ceau_pkg::SIZE_BYTE,
                  16'h0, 32'h0, 32'h0, 4'd3, 32'h0000_0012);
        queue_req(ceau_pkg::REQ_WRITE, ceau_pkg::MODE_DREG, 3'd0, ceau_pkg::SIZE_WORD,
                  16'h0, 32'h0, 32'h0, 4'd3, 32'h1234_ABCD);
        queue_req(ceau_pkg::REQ_WRITE, ceau_pkg::MODE_DREG, 3'd0, ceau_pkg::SIZE_WORD,
                  16'h0, 32'h0, 32'h0, 4'd10, 32'h0000_8000);
        queue_req(ceau_pkg::REQ_WRITE, ceau_pkg::MODE_DREG, 3'd0, ceau_pkg::SIZE_BYTE,
                  16'h0, 32'h0, 32'h0, 4'd9, 32'hFFFF_FF80);
        queue_req(ceau_pkg::REQ_WRITE, ceau_pkg::MODE_DREG, 3'd0, SZ_ODD,
                  16'h0, 32'h0, 32'h0, 4'd0, 32'hDEAD_BEEF);
        // register direct and indirect modes
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_DREG, 3'd3, ceau_pkg::SIZE_WORD,
                  16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_AREG, 3'd2, SZ_LONG,
                  16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_IND, 3'd2, ceau_pkg::SIZE_WORD,
                  16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        // stack pointer byte steps, ordinary byte step, odd size step
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_POSTINC, ceau_pkg::SP_REG,
                  ceau_pkg::SIZE_BYTE, 16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_PREDEC, ceau_pkg::SP_REG,
                  ceau_pkg::SIZE_BYTE, 16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_PREDEC, 3'd1, ceau_pkg::SIZE_BYTE,
                  16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_POSTINC, 3'd2, SZ_ODD,
                  16'h0, 32'h0, 32'h0, 4'd0, 32'h0);
        // displacement and index modes: word index, long address index
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_DISP, 3'd2, ceau_pkg::SIZE_WORD,
                  16'h8000, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_INDEX, 3'd1, SZ_LONG,
                  16'h3080, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_INDEX, 3'd0, ceau_pkg::SIZE_BYTE,
                  16'hA87F, 32'h0, 32'h0, 4'd0, 32'h0);
        // mode 7 submodes
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_ABS_W,
                  ceau_pkg::SIZE_WORD, 16'hFFFF, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_ABS_L, SZ_LONG,
                  16'h0, 32'hFFFF_FFFF, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_PC_DISP,
                  ceau_pkg::SIZE_WORD, 16'h0004, 32'h0, 32'hFFFF_FFFE, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_PC_IDX, SZ_LONG,
                  16'hF0FE, 32'h0, 32'h0000_0100, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_IMM,
                  ceau_pkg::SIZE_BYTE, 16'h12FF, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_IMM,
                  ceau_pkg::SIZE_WORD, 16'hFFFF, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, ceau_pkg::SUB_IMM, SZ_ODD,
                  16'h0, 32'h8000_0001, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, SUB_SPARE_LO,
                  ceau_pkg::SIZE_BYTE, 16'hFFFF, 32'h0, 32'h0, 4'd0, 32'h0);
        queue_req(ceau_pkg::REQ_DECODE, ceau_pkg::MODE_EXT, SUB_SPARE_HI, SZ_LONG,
                  16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0, 32'h0);

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            slot.req       = random_request();
            slot.wait_idle = (i == PAUSE_AT);
            request_fifo.push_back(slot);
        end

        // wait for the pipe to drain, then watch for stray items
        @(posedge i_clk);
        while (!i_rst_n || request_fifo.size() != 0 || s_valid || expected_ops.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_ops.size() == 0) begin
            $display("PASS cpu_effective_address_unit");
        end else begin
            $display("FAIL cpu_effective_address_unit");
        end
        $finish;
    end

endmodule
